FILE: src/ppp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline progress projector package
// Shared widths, command codes, queue item type and back end state encoding.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int COORD_W        = 24;
  localparam int CFG_W          = 24;
  localparam int CFG_IDX_W      = 2;
  localparam int PROG_W         = 31;
  localparam int MAX_POINTS_DEF = 64;
  localparam int FRAC_BITS      = 16;
  // Near-tie tolerance: 1e-4 m rounded to the nearest LSB.
  localparam int TIE_TOL        = ((1 << FRAC_BITS) + 5000) / 10000;

  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int ROOT_W = SUM_W / 2;
  localparam int DIST_W = 32;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [PROG_W-1:0]    PROG_MAX    = {PROG_W{1'b1}};
  localparam logic [CFG_IDX_W-1:0] REG_START_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y = 2'd1;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } ppp_cmd_t;

  typedef struct packed {
    ppp_cmd_t                   cmd;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
  } ppp_item_t;

  typedef struct packed {
    logic      valid;
    ppp_item_t item;
  } ppp_head_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_READ,
    B_LOAD,
    B_MUL,
    B_LEN_GO,
    B_LEN_WAIT,
    B_SORT,
    B_LAT_GO,
    B_LAT_WAIT,
    B_PROJ_GO,
    B_PROJ_WAIT,
    B_CROSS_GO,
    B_CROSS_WAIT,
    B_UPDATE,
    B_DONE
  } ppp_bstate_t;

endpackage

FILE: src/ppp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline progress projector front end
// Takes input transfers, classifies the command and queues useful items.
// ----------------------------------------------------------------------------
module ppp_front import ppp_pkg::*; (
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                cmd,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic                      q_full,
  output logic                      q_push,
  output ppp_item_t                 q_item
);

  ppp_cmd_t cmd_code;

  assign cmd_code = ppp_cmd_t'(cmd);
  assign in_ready = !q_full;

  // The unused command code has no effect, so it never enters the queue.
  assign q_push = in_valid && !q_full && (cmd_code != CMD_NOP);

  always_comb begin
    q_item.cmd = cmd_code;
    q_item.x   = point_x;
    q_item.y   = point_y;
  end

endmodule

FILE: src/ppp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline progress projector command queue
// Short queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ppp_fifo import ppp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  ppp_item_t push_item,
  output logic      full,
  input  logic      pop,
  output ppp_head_t head
);

  ppp_item_t               slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr;
  logic [FIFO_PTR_W-1:0]   rd_ptr;
  logic [FIFO_CNT_W-1:0]   fill;

  assign full       = (fill == FIFO_CNT_W'(FIFO_DEPTH));
  assign head.valid = (fill != '0);
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: src/ppp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline progress projector back end
// Holds the path, walks its segments for a query with a shared multiplier,
// an iterative square root and a bit-serial divider, and registers results.
// ----------------------------------------------------------------------------
module ppp_back import ppp_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic signed [COORD_W-1:0] start_x,
  input  logic signed [COORD_W-1:0] start_y,
  input  ppp_head_t                 head,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [PROG_W-1:0]         progress,
  output logic                      path_overflow
);

  localparam int AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW     = $clog2(MAX_POINTS + 1);
  localparam int CUM_A  = ROOT_W + CW + 1;
  localparam int CUM_W  = (CUM_A > PROG_W) ? CUM_A : PROG_W + 1;
  localparam int PI_W   = 4;
  localparam int DCNT_W = $clog2(SUM_W);
  localparam logic [PI_W-1:0] PI_LAST = PI_W'(10);

  ppp_bstate_t state, state_next;

  logic [2*COORD_W-1:0] mem [MAX_POINTS];
  logic [2*COORD_W-1:0] rd_data;
  logic                 mem_we;
  logic                 res_load;

  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic          ovf;

  logic signed [COORD_W-1:0] cx, cy, sx, sy, ex, ey;
  logic signed [COORD_W-1:0] e_x, e_y;
  logic signed [DIFF_W-1:0]  dx, dy, rx, ry, qx, qy;
  logic                      zseg, empty_q, have, lat_qq;

  logic [PI_W-1:0]          pi, pd;
  logic signed [DIFF_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  prod_ext, tmp, len2, dot, cr, rr, qq;

  logic [ROOT_W-1:0] len, proj;
  logic [DIST_W-1:0] lat, best_dist;
  logic [CUM_W-1:0]  cum, best_prog, cand;
  logic [DIST_W:0]   lat_tol, dist_gap;
  logic              win;

  logic             sq_start, sq_run;
  logic [SUM_W-1:0] sq_in, sq_v, sq_res, sq_bit, sq_trial;

  logic              dv_start, dv_run;
  logic [SUM_W-1:0]  dv_in, dv_num, dv_q;
  logic [ROOT_W:0]   dv_rem, dv_sh;
  logic [ROOT_W-1:0] dv_den;
  logic [DCNT_W-1:0] dv_cnt;

  // ---------------------------------------------------------------- path store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[AW-1:0]] <= {head.item.x, head.item.y};
    end
    rd_data <= mem[idx[AW-1:0]];
  end

  // ------------------------------------------------------------ state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_pop && head.item.cmd == CMD_QUERY) begin
          state_next = (count == '0) ? B_LOAD : B_READ;
        end
      end
      B_READ:   state_next = B_LOAD;
      B_LOAD:   state_next = B_MUL;
      B_MUL: begin
        if (pi == PI_LAST) begin
          state_next = zseg ? B_LAT_GO : B_LEN_GO;
        end
      end
      B_LEN_GO:   state_next = B_LEN_WAIT;
      B_LEN_WAIT: state_next = sq_run ? B_LEN_WAIT : B_SORT;
      B_SORT: begin
        if (dot[SUM_W-1] || dot == '0 || dot >= len2) begin
          state_next = B_LAT_GO;
        end else begin
          state_next = B_PROJ_GO;
        end
      end
      B_LAT_GO:     state_next = B_LAT_WAIT;
      B_LAT_WAIT:   state_next = sq_run ? B_LAT_WAIT : B_UPDATE;
      B_PROJ_GO:    state_next = B_PROJ_WAIT;
      B_PROJ_WAIT:  state_next = dv_run ? B_PROJ_WAIT : B_CROSS_GO;
      B_CROSS_GO:   state_next = B_CROSS_WAIT;
      B_CROSS_WAIT: state_next = dv_run ? B_CROSS_WAIT : B_UPDATE;
      B_UPDATE: begin
        if (empty_q || CW'(idx + 1'b1) == count) begin
          state_next = B_DONE;
        end else begin
          state_next = B_READ;
        end
      end
      B_DONE:   state_next = res_load ? B_IDLE : B_DONE;
      default:  state_next = B_IDLE;
    endcase
  end

  // A finished query waits in B_DONE until the result register is free and
  // pops nothing meanwhile; once in idle, pops go on while a result is held.
  always_comb begin
    q_pop    = (state == B_IDLE) && head.valid;
    res_load = (state == B_DONE) && (!out_valid || out_ready);
    mem_we   = q_pop && (head.item.cmd == CMD_APPEND) && (count < CW'(MAX_POINTS));
    sq_start = (state == B_LEN_GO) || (state == B_LAT_GO);
    sq_in    = (state == B_LEN_GO) ? len2 : (lat_qq ? qq : rr);
    dv_start = (state == B_PROJ_GO) || (state == B_CROSS_GO);
    dv_in    = (state == B_PROJ_GO) ? dot : (cr[SUM_W-1] ? -cr : cr);
  end

  // ---------------------------------------------------------------- datapath
  assign e_x = empty_q ? sx : rd_data[2*COORD_W-1:COORD_W];
  assign e_y = empty_q ? sy : rd_data[COORD_W-1:0];

  always_comb begin
    unique case (pi)
      4'd0:    begin mul_a = dx; mul_b = dx; end
      4'd1:    begin mul_a = dy; mul_b = dy; end
      4'd2:    begin mul_a = rx; mul_b = dx; end
      4'd3:    begin mul_a = ry; mul_b = dy; end
      4'd4:    begin mul_a = rx; mul_b = dy; end
      4'd5:    begin mul_a = ry; mul_b = dx; end
      4'd6:    begin mul_a = rx; mul_b = rx; end
      4'd7:    begin mul_a = ry; mul_b = ry; end
      4'd8:    begin mul_a = qx; mul_b = qx; end
      4'd9:    begin mul_a = qy; mul_b = qy; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod_ext = {{(SUM_W - PROD_W){prod[PROD_W-1]}}, prod};

  // A proper segment wins clearly when closer by more than the tolerance,
  // and within the tolerance only when it lies further along the path.
  assign cand     = zseg ? cum : cum + CUM_W'(proj);
  assign lat_tol  = {1'b0, lat} + (DIST_W + 1)'(TIE_TOL);
  assign dist_gap = (lat >= best_dist) ? {1'b0, lat - best_dist} : {1'b0, best_dist - lat};
  always_comb begin
    if (!have) begin
      win = 1'b1;
    end else if (zseg) begin
      win = lat < best_dist;
    end else begin
      win = (lat_tol < {1'b0, best_dist}) ||
            (dist_gap <= (DIST_W + 1)'(TIE_TOL) && cand > best_prog);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (q_pop) begin
            unique case (head.item.cmd)
              CMD_APPEND: begin
                if (count < CW'(MAX_POINTS)) begin
                  count <= count + 1'b1;
                end else begin
                  ovf <= 1'b1;
                end
              end
              CMD_CLEAR: begin
                count <= '0;
                ovf   <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        cx      <= head.item.x;
        cy      <= head.item.y;
        sx      <= start_x;
        sy      <= start_y;
        idx     <= '0;
        cum     <= '0;
        have    <= 1'b0;
        empty_q <= (count == '0);
      end
      B_LOAD: begin
        ex     <= e_x;
        ey     <= e_y;
        dx     <= DIFF_W'(e_x) - DIFF_W'(sx);
        dy     <= DIFF_W'(e_y) - DIFF_W'(sy);
        rx     <= DIFF_W'(cx) - DIFF_W'(sx);
        ry     <= DIFF_W'(cy) - DIFF_W'(sy);
        qx     <= DIFF_W'(cx) - DIFF_W'(e_x);
        qy     <= DIFF_W'(cy) - DIFF_W'(e_y);
        zseg   <= (e_x == sx) && (e_y == sy);
        lat_qq <= 1'b1;
        pi     <= '0;
      end
      B_MUL: begin
        // Products issue one per cycle; each pair is summed in the cycle after its second product.
        if (pi < PI_LAST) begin
          prod <= mul_a * mul_b;
          pd   <= pi;
        end
        if (pi != '0) begin
          unique case (pd)
            4'd1:    len2 <= tmp + prod_ext;
            4'd3:    dot  <= tmp + prod_ext;
            4'd5:    cr   <= tmp - prod_ext;
            4'd7:    rr   <= tmp + prod_ext;
            4'd9:    qq   <= tmp + prod_ext;
            default: tmp  <= prod_ext;
          endcase
        end
        pi <= pi + 1'b1;
      end
      B_LEN_WAIT: begin
        len <= sq_res[ROOT_W-1:0];
      end
      B_SORT: begin
        if (dot[SUM_W-1] || dot == '0) begin
          proj   <= '0;
          lat_qq <= 1'b0;
        end else if (dot >= len2) begin
          proj   <= len;
          lat_qq <= 1'b1;
        end
      end
      B_LAT_WAIT: begin
        lat <= DIST_W'(sq_res);
      end
      B_PROJ_WAIT: begin
        proj <= (dv_q > SUM_W'(len)) ? len : dv_q[ROOT_W-1:0];
      end
      B_CROSS_WAIT: begin
        lat <= dv_q[DIST_W-1:0];
      end
      B_UPDATE: begin
        if (empty_q) begin
          best_prog <= CUM_W'(lat);
        end else if (win) begin
          best_dist <= lat;
          best_prog <= cand;
          have      <= 1'b1;
        end
        if (!zseg) begin
          cum <= cum + CUM_W'(len);
        end
        sx  <= ex;
        sy  <= ey;
        idx <= idx + 1'b1;
      end
      B_DONE: begin
        if (res_load) begin
          progress      <= (best_prog > CUM_W'(PROG_MAX)) ? PROG_MAX : best_prog[PROG_W-1:0];
          path_overflow <= ovf;
        end
      end
      default: begin
      end
    endcase
  end

  // ------------------------------------------------- square root, 2 bits/cycle
  assign sq_trial = sq_res + sq_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_run <= 1'b0;
    end else if (sq_start) begin
      sq_run <= 1'b1;
    end else if (sq_run && sq_bit[0]) begin
      sq_run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_start) begin
      sq_v   <= sq_in;
      sq_res <= '0;
      sq_bit <= SUM_W'(1) << (SUM_W - 2);
    end else if (sq_run) begin
      if (sq_v >= sq_trial) begin
        sq_v   <= sq_v - sq_trial;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  // ------------------------------------------------ restoring divider, 1 bit/cycle
  assign dv_sh = {dv_rem[ROOT_W-1:0], dv_num[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_run <= 1'b0;
    end else if (dv_start) begin
      dv_run <= 1'b1;
    end else if (dv_run && dv_cnt == DCNT_W'(SUM_W - 1)) begin
      dv_run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_start) begin
      dv_num <= dv_in;
      dv_den <= len;
      dv_rem <= '0;
      dv_q   <= '0;
      dv_cnt <= '0;
    end else if (dv_run) begin
      if (dv_sh >= {1'b0, dv_den}) begin
        dv_rem <= dv_sh - {1'b0, dv_den};
        dv_q   <= {dv_q[SUM_W-2:0], 1'b1};
      end else begin
        dv_rem <= dv_sh;
        dv_q   <= {dv_q[SUM_W-2:0], 1'b0};
      end
      dv_num <= dv_num << 1;
      dv_cnt <= dv_cnt + 1'b1;
    end
  end

endmodule

FILE: src/polyline_progress_projector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline progress projector
// Keeps a polyline from a configured start point and returns the arc length
// progress of a position projected onto the nearest segment.
// ----------------------------------------------------------------------------
// Append and clear are applied as the back end pops them. A query with an
// empty path returns the distance from the start point; otherwise the back
// end works through each stored point with the shared multiplier, the 26-step
// square root and two 52-step divisions. Items queue two deep while the back
// end works or a result waits. Synchronous reset empties the path, clears the
// drop flag and the queue, and sets the start point to zero.
module polyline_progress_projector_unit import ppp_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                cmd,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [PROG_W-1:0]         progress,
  output logic                      path_overflow
);

  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic                      q_full;
  logic                      q_push;
  ppp_item_t                 q_item;
  logic                      q_pop;
  ppp_head_t                 q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0;
      start_y <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_START_X) begin
        start_x <= cfg_data;
      end
      if (cfg_index == REG_START_Y) begin
        start_y <= cfg_data;
      end
    end
  end

  ppp_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .point_x  (point_x),
    .point_y  (point_y),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  ppp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head)
  );

  ppp_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .start_x       (start_x),
    .start_y       (start_y),
    .head          (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .progress      (progress),
    .path_overflow (path_overflow)
  );

endmodule

FILE: src/ppp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline progress projector port checker
// Watches the top level ports for stalled result hold, reset behavior and known handshakes.
// ----------------------------------------------------------------------------
module ppp_checker import ppp_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [PROG_W-1:0] progress,
  input logic              path_overflow
);

  // A stalled result keeps its value until the transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(progress) && $stable(path_overflow))
    else $error("result changed while stalled");

  // Reset leaves no result pending and an empty queue ready to take items.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  // A query must pass through the back end states, so no result shows right after reset.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(rst) && !$past(rst, 2))
    else $error("result appeared too soon after reset");

  // The handshake outputs are always driven to known levels out of reset.
  a_handshake_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown(out_valid) && !$isunknown(in_ready))
    else $error("handshake output unknown");

endmodule

bind polyline_progress_projector_unit ppp_checker u_ppp_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline progress projector testbench
// Appends path points, clears the path and queries progress under random
// handshake gaps and a long output stall. An internal model of the path
// predicts each query result, and the monitor checks every output transfer
// against it in order.
// ----------------------------------------------------------------------------
module tb;
  import ppp_pkg::*;

  localparam int  NPTS       = 64;
  localparam int  TOL        = ((1 << 16) + 5000) / 10000;
  localparam int  CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [PROG_W-1:0] prog;
    logic              ovf;
  } prog_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] cmd = 2'd0;
  logic signed [COORD_W-1:0] point_x = '0;
  logic signed [COORD_W-1:0] point_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PROG_W-1:0] progress;
  logic path_overflow;

  polyline_progress_projector_unit i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .point_x(point_x),
    .point_y(point_y), .out_valid(out_valid), .out_ready(out_ready),
    .progress(progress), .path_overflow(path_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ppp_item_t    pending_items[$];
  prog_result_t expected_progress[$];
  int           mismatches = 0;
  int           cycle_count = 0;
  int           stall_left = 0;
  bit           stall_request = 0;
  bit           stall_done = 0;

  // Shadow copy of the path and start point.
  longint    path_x[NPTS];
  longint    path_y[NPTS];
  int        path_len = 0;
  bit        path_dropped = 0;
  longint    origin_x = 0;
  longint    origin_y = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned span(longint dx, longint dy);
    return int_sqrt(longint'(dx * dx) + longint'(dy * dy));
  endfunction

  function automatic longint unsigned arc_progress(longint cx, longint cy);
    longint sx, sy, ex, ey, dx, dy, rx, ry, dot, cr;
    longint unsigned cum, best_prog, best_dist, len2, len, proj, lat, cand, d, gap;
    bit have;
    sx = origin_x;
    sy = origin_y;
    cum = 0;
    best_prog = 0;
    best_dist = 0;
    have = 0;
    if (path_len == 0) return span(cx - sx, cy - sy);
    for (int i = 0; i < path_len; i++) begin
      ex = path_x[i];
      ey = path_y[i];
      dx = ex - sx;
      dy = ey - sy;
      if (dx == 0 && dy == 0) begin
        // A repeated point only wins on a strictly smaller distance.
        d = span(cx - ex, cy - ey);
        if (!have || d < best_dist) begin
          have = 1;
          best_dist = d;
          best_prog = cum;
        end
      end else begin
        len2 = dx * dx + dy * dy;
        len = int_sqrt(len2);
        rx = cx - sx;
        ry = cy - sy;
        dot = rx * dx + ry * dy;
        if (dot <= 0) begin
          proj = 0;
          lat = span(rx, ry);
        end else if (longint'(dot) >= longint'(len2)) begin
          proj = len;
          lat = span(cx - ex, cy - ey);
        end else begin
          cr = rx * dy - ry * dx;
          if (cr < 0) cr = -cr;
          proj = longint'(dot) / len;
          if (proj > len) proj = len;
          lat = longint'(cr) / len;
        end
        cand = cum + proj;
        gap = (lat >= best_dist) ? lat - best_dist : best_dist - lat;
        if (!have || lat + TOL < best_dist || (gap <= TOL && cand > best_prog)) begin
          have = 1;
          best_dist = lat;
          best_prog = cand;
        end
        cum += len;
      end
      sx = ex;
      sy = ey;
    end
    return best_prog;
  endfunction

  function automatic void apply_command(ppp_item_t it);
    prog_result_t r;
    longint unsigned p;
    case (it.cmd)
      CMD_APPEND: begin
        if (path_len < NPTS) begin
          path_x[path_len] = longint'(it.x);
          path_y[path_len] = longint'(it.y);
          path_len++;
        end else begin
          path_dropped = 1;
        end
      end
      CMD_CLEAR: begin
        path_len = 0;
        path_dropped = 0;
      end
      CMD_QUERY: begin
        p = arc_progress(longint'(it.x), longint'(it.y));
        if (p > longint'(PROG_MAX)) p = longint'(PROG_MAX);
        r.prog = p[PROG_W-1:0];
        r.ovf = path_dropped;
        expected_progress = {expected_progress, r};
      end
      default: ;
    endcase
  endfunction

  // Random gaps everywhere except a quiet window early in the run.
  function automatic bit take_gap();
    if (cycle_count > 2000 && cycle_count < 6000) return 0;
    return ($urandom_range(99) < 29);
  endfunction

  // Sender.
  always @(posedge clk) begin
    ppp_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) apply_command('{ppp_cmd_t'(cmd), point_x, point_y});
      if (pending_items.size() != 0 && !take_gap()) begin
        it = pending_items.pop_front();
        in_valid <= 1'b1;
        cmd <= it.cmd;
        point_x <= it.x;
        point_y <= it.y;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver and checker.
  always @(posedge clk) begin
    prog_result_t e;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_progress.size() == 0) begin
          if (mismatches < 10) $display("unexpected result: progress %0d overflow %0d",
                                        progress, path_overflow);
          mismatches++;
        end else begin
          e = expected_progress.pop_front();
          if (progress !== e.prog || path_overflow !== e.ovf) begin
            if (mismatches < 10)
              $display("mismatch: expected progress %0d overflow %0d, got %0d %0d",
                       e.prog, e.ovf, progress, path_overflow);
            mismatches++;
          end
        end
      end
      if (stall_request && !stall_done) begin
        stall_done <= 1'b1;
        stall_left <= 600;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !take_gap();
      end
    end
  end

  task automatic add_item(ppp_cmd_t c, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    ppp_item_t it;
    it = '{c, x, y};
    pending_items = {pending_items, it};
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_progress.size() != 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_origin(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_START_X;
    cfg_data <= x;
    @(posedge clk);
    cfg_index <= REG_START_Y;
    cfg_data <= y;
    @(posedge clk);
    cfg_we <= 1'b0;
    origin_x = longint'($signed(x));
    origin_y = longint'($signed(y));
  endtask

  function automatic logic [COORD_W-1:0] near_coord(longint base);
    if ($urandom_range(3) == 0) return COORD_W'($urandom);
    return COORD_W'(base + $signed($urandom_range(8 << 16)) - (4 << 16));
  endfunction

  // A well-formed path with random points, then a few queries near it.
  task automatic add_random_path();
    int n;
    n = $urandom_range(6);
    add_item(CMD_CLEAR, COORD_W'($urandom), COORD_W'($urandom));
    for (int i = 0; i < n; i++) begin
      if (i != 0 && $urandom_range(5) == 0)
        add_item(CMD_APPEND, pending_items[$].x, pending_items[$].y);
      else
        add_item(CMD_APPEND, near_coord(origin_x), near_coord(origin_y));
    end
    for (int i = 0; i <= $urandom_range(3); i++) begin
      if ($urandom_range(9) == 0)
        add_item(CMD_NOP, COORD_W'($urandom), COORD_W'($urandom));
      add_item(CMD_QUERY, near_coord(origin_x), near_coord(origin_y));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty path, repeated point, clamping at both ends, extremes.
    add_item(CMD_QUERY, 24'd0, 24'd0);
    add_item(CMD_QUERY, 24'h7fffff, 24'h800000);
    add_item(CMD_NOP, 24'hffffff, 24'hffffff);
    add_item(CMD_APPEND, 24'h010000, 24'd0);
    add_item(CMD_APPEND, 24'h010000, 24'd0);
    add_item(CMD_APPEND, 24'h010000, 24'h010000);
    add_item(CMD_QUERY, 24'h008000, 24'd100);
    add_item(CMD_QUERY, 24'h030000, 24'h030000);
    add_item(CMD_QUERY, 24'hfffffb, 24'hfffffb);
    add_item(CMD_QUERY, 24'h018000, 24'h008000);
    add_item(CMD_QUERY, 24'h010000, 24'd0);
    add_item(CMD_CLEAR, 24'd0, 24'd0);
    add_item(CMD_QUERY, 24'h800000, 24'h7fffff);
    add_item(CMD_APPEND, 24'h800000, 24'h800000);
    add_item(CMD_APPEND, 24'h7fffff, 24'h7fffff);
    add_item(CMD_QUERY, 24'd0, 24'd0);
    add_item(CMD_QUERY, 24'h7fffff, 24'h800000);
    wait_idle();

    set_origin(24'h800000, 24'h7fffff);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= 2'd2;
    cfg_data <= 24'hffffff;
    @(posedge clk);
    cfg_we <= 1'b0;
    for (int k = 0; k < 2; k++) add_random_path();
    wait_idle();

    // Full path and dropped appends, then the long receiver stall.
    set_origin(24'h7fffff, 24'h800000);
    add_item(CMD_CLEAR, 24'd0, 24'd0);
    for (int i = 0; i < NPTS + 2; i++)
      add_item(CMD_APPEND, (i % 2) ? 24'h800000 : 24'h7fffff,
               (i % 4 < 2) ? 24'h7fffff : 24'h800000);
    add_item(CMD_QUERY, 24'd0, 24'd0);
    add_item(CMD_QUERY, 24'h7fffff, 24'h7fffff);
    add_item(CMD_CLEAR, 24'd0, 24'd0);
    add_item(CMD_QUERY, 24'h123456, 24'h654321);
    wait_idle();

    set_origin(24'd0, 24'd0);
    stall_request = 1;
    for (int i = 0; i < 8; i++) begin
      add_item(CMD_QUERY, COORD_W'($urandom_range(1 << 18)), 24'd0);
      add_item(CMD_APPEND, COORD_W'(i << 16), COORD_W'($urandom_range(1 << 16)));
    end
    for (int k = 0; k < 1; k++) add_random_path();
    wait_idle();

    set_origin(COORD_W'($urandom), COORD_W'($urandom));
    for (int k = 0; k < 1; k++) add_random_path();
    wait_idle();

    set_origin(24'h7fffff, 24'h7fffff);
    for (int k = 0; k < 1; k++) add_random_path();
    wait_idle();

    repeat (200) @(posedge clk);
    if (expected_progress.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
